### rtl/edge_list_to_csr_builder_assert.svh
// Assertion macros shared by the edge list to CSR builder.
`ifndef EDGE_LIST_TO_CSR_BUILDER_ASSERT_SVH
`define EDGE_LIST_TO_CSR_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
`define ECB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("Assertion failed.");
`define ECB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("Assertion failed.");
`else
`define ECB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ECB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/ecb_pkg.sv
// Shared types and constants of the edge list to CSR builder.
package ecb_pkg;

  localparam int DefMaxVertices = 1024;
  localparam int DefMaxEdges    = 4096;

  localparam int FuncW    = 2;
  localparam int IdW      = 32;
  localparam int IdxW     = 13;
  localparam int StatusW  = 3;
  localparam int ValueW   = 14;
  localparam int MaxDegW  = 13;
  localparam int TotalW   = 14;
  localparam int VcW      = 11;
  localparam logic [VcW-1:0] VcReset = 11'd1024;

  localparam int QueueDepth = 2;

  typedef enum logic [FuncW-1:0] {
    OP_ADD    = 2'd0,
    OP_FIN    = 2'd1,
    OP_RD_OFF = 2'd2,
    OP_RD_NB  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_SELF  = 3'd1,
    ST_RANGE = 3'd2,
    ST_FULL  = 3'd3,
    ST_PHASE = 3'd4,
    ST_INDEX = 3'd5
  } status_e;

  typedef struct packed {
    op_e              op;
    status_e          status;
    logic [IdxW-1:0]  idx;
  } cmd_hdr_t;

endpackage

### rtl/ecb_fifo.sv
// Short command queue between the front and the back of the builder.
module ecb_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] head_o,
  output logic         full_o,
  output logic         empty_o
);
  import ecb_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [W-1:0]    slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

### rtl/ecb_front.sv
// Front end: accepts input words, checks phase, range, self-loops, capacity and read indices, queues commands.
module ecb_front #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ecb_pkg::FuncW-1:0]    func_i,
  input  logic [ecb_pkg::IdW-1:0]      edge_source_i,
  input  logic [ecb_pkg::IdW-1:0]      edge_target_i,
  input  logic [ecb_pkg::IdxW-1:0]     read_index_i,
  input  logic [ecb_pkg::VcW-1:0]      vertex_count_i,
  input  logic                         clearing_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output ecb_pkg::cmd_hdr_t            q_hdr_o,
  output logic [$clog2(MAX_VERTICES)-1:0] q_src_o,
  output logic [$clog2(MAX_VERTICES)-1:0] q_dst_o
);
  import ecb_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int ECW = $clog2(MAX_EDGES + 1);

  logic            done_q, done_d;
  logic [ECW-1:0]  kept_q, kept_d;
  logic [31:0]     nv;
  logic            accept;
  op_e             op;
  status_e         st;

  assign in_stall_o = q_full_i || clearing_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = op_e'(func_i);
  assign nv = (32'(vertex_count_i) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES)
                                                        : 32'(vertex_count_i);

  always_comb begin
    st = ST_OK;
    unique case (op)
      OP_ADD: begin
        if (done_q) begin
          st = ST_PHASE;
        end else if (edge_source_i >= nv || edge_target_i >= nv) begin
          st = ST_RANGE;
        end else if (edge_source_i == edge_target_i) begin
          st = ST_SELF;
        end else if (kept_q == ECW'(MAX_EDGES)) begin
          st = ST_FULL;
        end
      end
      OP_FIN: begin
        if (done_q) begin
          st = ST_PHASE;
        end
      end
      OP_RD_OFF: begin
        if (!done_q) begin
          st = ST_PHASE;
        end else if (32'(read_index_i) > nv) begin
          st = ST_INDEX;
        end
      end
      OP_RD_NB: begin
        if (!done_q) begin
          st = ST_PHASE;
        end else if (32'(read_index_i) >= (32'(kept_q) << 1)) begin
          st = ST_INDEX;
        end
      end
      default: st = ST_PHASE;
    endcase
  end

  always_comb begin
    done_d = done_q;
    kept_d = kept_q;
    if (accept && st == ST_OK) begin
      if (op == OP_ADD) begin
        kept_d = kept_q + 1'b1;
      end
      if (op == OP_FIN) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      kept_q <= '0;
    end else begin
      done_q <= done_d;
      kept_q <= kept_d;
    end
  end

  assign q_push_o       = accept;
  assign q_hdr_o.op     = op;
  assign q_hdr_o.status = st;
  assign q_hdr_o.idx    = read_index_i;
  assign q_src_o        = VW'(edge_source_i);
  assign q_dst_o        = VW'(edge_target_i);

endmodule

### rtl/ecb_back.sv
// Back end: edge and degree stores, prefix sweep, neighbor scatter and reads.
module ecb_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  ecb_pkg::cmd_hdr_t               q_hdr_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] q_src_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] q_dst_i,
  output logic                            q_pop_o,
  output logic                            clearing_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ecb_pkg::StatusW-1:0]     status_o,
  output logic [ecb_pkg::ValueW-1:0]      read_value_o,
  output logic [ecb_pkg::MaxDegW-1:0]     max_degree_out_o,
  output logic [ecb_pkg::TotalW-1:0]      total_entries_o
);
  import ecb_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int NBD = 2 * MAX_EDGES;
  localparam int NBW = $clog2(NBD);
  localparam int EW  = $clog2(NBD + 1);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_EXEC   = 12'b0000_0000_0100,
    S_ADD_WA = 12'b0000_0000_1000,
    S_ADD_WB = 12'b0000_0001_0000,
    S_PFX    = 12'b0000_0010_0000,
    S_SC_RE  = 12'b0000_0100_0000,
    S_SC_RC  = 12'b0000_1000_0000,
    S_SC_WA  = 12'b0001_0000_0000,
    S_SC_WB  = 12'b0010_0000_0000,
    S_READ   = 12'b0100_0000_0000,
    S_RESP   = 12'b1000_0000_0000
  } state_e;

  state_e          state_q, state_d;
  cmd_hdr_t        cmd_q, cmd_d;
  logic [VW-1:0]   cmd_a_q, cmd_a_d, cmd_b_q, cmd_b_d;
  logic [VW-1:0]   clr_q, clr_d;
  logic [VCW-1:0]  v_q, v_d;
  logic            pend_q, pend_d;
  logic [VW-1:0]   pidx_q, pidx_d;
  logic [EW-1:0]   acc_q, acc_d;
  logic [EW-1:0]   maxdeg_q, maxdeg_d;
  logic [EW-1:0]   total_q, total_d;
  logic [ECW-1:0]  ecnt_q, ecnt_d;
  logic [ECW-1:0]  e_q, e_d;
  status_e         res_st_q, res_st_d;
  logic [EW-1:0]   res_val_q, res_val_d;

  logic            out_valid_q;
  status_e         out_st_q;
  logic [EW-1:0]   out_val_q, out_maxdeg_q, out_total_q;

  logic [EW-1:0]   deg_mem [MAX_VERTICES];
  logic [EW-1:0]   off_mem [MAX_VERTICES];
  logic [VW-1:0]   ef_mem  [MAX_EDGES];
  logic [VW-1:0]   es_mem  [MAX_EDGES];
  logic [VW-1:0]   nb_mem  [NBD];

  logic [EW-1:0]   deg_a_q, deg_b_q, off_q;
  logic [VW-1:0]   ea_q, eb_q, nb_q;

  logic            deg_we, off_we, edge_we, nb_we;
  logic [VW-1:0]   deg_ra, deg_rb, deg_wa, off_wa;
  logic [EW-1:0]   deg_wd, off_wd;
  logic [NBW-1:0]  nb_wa;
  logic [VW-1:0]   nb_wd;
  logic            slot_free;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign clearing_o = (state_q == S_CLEAR);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cmd_a_d   = cmd_a_q;
    cmd_b_d   = cmd_b_q;
    clr_d     = clr_q;
    v_d       = v_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    acc_d     = acc_q;
    maxdeg_d  = maxdeg_q;
    total_d   = total_q;
    ecnt_d    = ecnt_q;
    e_d       = e_q;
    res_st_d  = res_st_q;
    res_val_d = res_val_q;
    q_pop_o   = 1'b0;
    deg_ra    = cmd_a_q;
    deg_rb    = cmd_b_q;
    deg_we    = 1'b0;
    deg_wa    = cmd_a_q;
    deg_wd    = '0;
    off_we    = 1'b0;
    off_wa    = pidx_q;
    off_wd    = acc_q;
    edge_we   = 1'b0;
    nb_we     = 1'b0;
    nb_wa     = NBW'(deg_a_q);
    nb_wd     = eb_q;
    unique case (state_q)
      S_CLEAR: begin
        deg_we = 1'b1;
        deg_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == VW'(MAX_VERTICES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_hdr_i;
          cmd_a_d = q_src_i;
          cmd_b_d = q_dst_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_st_d  = cmd_q.status;
        res_val_d = '0;
        if (cmd_q.status != ST_OK) begin
          state_d = S_RESP;
        end else begin
          unique case (cmd_q.op)
            OP_ADD: begin
              edge_we = 1'b1;
              ecnt_d  = ecnt_q + 1'b1;
              state_d = S_ADD_WA;
            end
            OP_FIN: begin
              v_d     = '0;
              pend_d  = 1'b0;
              acc_d   = '0;
              state_d = S_PFX;
            end
            OP_RD_OFF: begin
              if (32'(cmd_q.idx) == 32'(MAX_VERTICES)) begin
                res_val_d = total_q;
                state_d   = S_RESP;
              end else begin
                state_d = S_READ;
              end
            end
            OP_RD_NB: state_d = S_READ;
            default:  state_d = S_RESP;
          endcase
        end
      end
      S_ADD_WA: begin
        deg_we  = 1'b1;
        deg_wa  = cmd_a_q;
        deg_wd  = deg_a_q + 1'b1;
        state_d = S_ADD_WB;
      end
      S_ADD_WB: begin
        deg_we  = 1'b1;
        deg_wa  = cmd_b_q;
        deg_wd  = deg_b_q + 1'b1;
        state_d = S_RESP;
      end
      S_PFX: begin
        deg_ra = v_q[VW-1:0];
        if (v_q != VCW'(MAX_VERTICES)) begin
          pend_d = 1'b1;
          pidx_d = v_q[VW-1:0];
          v_d    = v_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          off_we = 1'b1;
          deg_we = 1'b1;
          deg_wa = pidx_q;
          deg_wd = acc_q;
          acc_d  = acc_q + deg_a_q;
          if (deg_a_q > maxdeg_q) begin
            maxdeg_d = deg_a_q;
          end
        end else if (v_q == VCW'(MAX_VERTICES)) begin
          total_d = acc_q;
          e_d     = '0;
          state_d = S_SC_RE;
        end
      end
      S_SC_RE: begin
        if (e_q == ecnt_q) begin
          state_d = S_RESP;
        end else begin
          state_d = S_SC_RC;
        end
      end
      S_SC_RC: begin
        deg_ra  = ea_q;
        deg_rb  = eb_q;
        state_d = S_SC_WA;
      end
      S_SC_WA: begin
        deg_ra  = ea_q;
        deg_rb  = eb_q;
        nb_we   = 1'b1;
        nb_wa   = NBW'(deg_a_q);
        nb_wd   = eb_q;
        deg_we  = 1'b1;
        deg_wa  = ea_q;
        deg_wd  = deg_a_q + 1'b1;
        state_d = S_SC_WB;
      end
      S_SC_WB: begin
        deg_ra  = ea_q;
        deg_rb  = eb_q;
        nb_we   = 1'b1;
        nb_wa   = NBW'(deg_b_q);
        nb_wd   = ea_q;
        deg_we  = 1'b1;
        deg_wa  = eb_q;
        deg_wd  = deg_b_q + 1'b1;
        e_d     = e_q + 1'b1;
        state_d = S_SC_RE;
      end
      S_READ: begin
        res_val_d = (cmd_q.op == OP_RD_OFF) ? off_q : EW'(nb_q);
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      maxdeg_q    <= '0;
      total_q     <= '0;
      ecnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      maxdeg_q <= maxdeg_d;
      total_q  <= total_d;
      ecnt_q   <= ecnt_d;
      if (state_q == S_RESP && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cmd_a_q   <= cmd_a_d;
    cmd_b_q   <= cmd_b_d;
    v_q       <= v_d;
    pend_q    <= pend_d;
    pidx_q    <= pidx_d;
    acc_q     <= acc_d;
    e_q       <= e_d;
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
    if (state_q == S_RESP && slot_free) begin
      out_st_q     <= res_st_q;
      out_val_q    <= res_val_q;
      out_maxdeg_q <= maxdeg_q;
      out_total_q  <= total_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    deg_a_q <= deg_mem[deg_ra];
    deg_b_q <= deg_mem[deg_rb];
  end

  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[off_wa] <= off_wd;
    end
    off_q <= off_mem[VW'(cmd_q.idx)];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      ef_mem[ecnt_q[EIW-1:0]] <= cmd_a_q;
      es_mem[ecnt_q[EIW-1:0]] <= cmd_b_q;
    end
    ea_q <= ef_mem[e_q[EIW-1:0]];
    eb_q <= es_mem[e_q[EIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (nb_we) begin
      nb_mem[nb_wa] <= nb_wd;
    end
    nb_q <= nb_mem[NBW'(cmd_q.idx)];
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign read_value_o     = ValueW'(out_val_q);
  assign max_degree_out_o = MaxDegW'(out_maxdeg_q);
  assign total_entries_o  = TotalW'(out_total_q);

endmodule

### rtl/edge_list_to_csr_builder.sv
// Top level of the edge list to CSR builder.
// The input channel (in_valid_i / in_stall_o) takes one word per item: an
// edge to add, a finish command, an offset read or a neighbor read. Each
// item gives exactly one result word on the output channel (out_valid_o /
// out_stall_i) carrying a status, a read value, the maximum degree and the
// number of neighbor entries. The user must write the vertex count register
// through cfg_valid_i / cfg_ready_o only while the block is idle; the block
// itself does not enforce this. A front end checks each item and queues it;
// a back end executes it. With the back end idle, an added edge passes
// through a queue pop, a decode step, one read-modify-write per endpoint on
// the single degree write port and a result step. Reads pass through a
// memory read step, except for the final offset, and rejected items go from
// decode straight to the result. A finish runs the prefix sweep over all
// vertices and then the neighbor scatter over every stored edge. Items are
// executed one at a time. After reset the degree memory is cleared, and the
// input channel stalls meanwhile. When the receiver stalls, the result word
// holds, the back end stops at its next result and the queue fills up.
module edge_list_to_csr_builder #(
  parameter int MAX_VERTICES = ecb_pkg::DefMaxVertices,
  parameter int MAX_EDGES    = ecb_pkg::DefMaxEdges
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ecb_pkg::VcW-1:0]     cfg_vertex_count_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ecb_pkg::FuncW-1:0]   func_i,
  input  logic [ecb_pkg::IdW-1:0]     edge_source_i,
  input  logic [ecb_pkg::IdW-1:0]     edge_target_i,
  input  logic [ecb_pkg::IdxW-1:0]    read_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ecb_pkg::StatusW-1:0] status_o,
  output logic [ecb_pkg::ValueW-1:0]  read_value_o,
  output logic [ecb_pkg::MaxDegW-1:0] max_degree_out_o,
  output logic [ecb_pkg::TotalW-1:0]  total_entries_o
);
  import ecb_pkg::*;
`include "edge_list_to_csr_builder_assert.svh"

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int QW = $bits(cmd_hdr_t) + 2 * VW;

  logic [VcW-1:0] vertex_count_q;
  logic           clearing, q_full, q_empty, q_push, q_pop;
  cmd_hdr_t       push_hdr, head_hdr;
  logic [VW-1:0]  push_src, push_dst, head_src, head_dst;
  logic [QW-1:0]  head_word;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VcReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vertex_count_q <= cfg_vertex_count_i;
    end
  end

  ecb_front #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .edge_source_i  (edge_source_i),
    .edge_target_i  (edge_target_i),
    .read_index_i   (read_index_i),
    .vertex_count_i (vertex_count_q),
    .clearing_i     (clearing),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_hdr_o        (push_hdr),
    .q_src_o        (push_src),
    .q_dst_o        (push_dst)
  );

  ecb_fifo #(
    .W(QW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({push_hdr, push_src, push_dst}),
    .pop_i       (q_pop),
    .head_o      (head_word),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  assign {head_hdr, head_src, head_dst} = head_word;

  ecb_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_hdr_i          (head_hdr),
    .q_src_i          (head_src),
    .q_dst_i          (head_dst),
    .q_pop_o          (q_pop),
    .clearing_o       (clearing),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .max_degree_out_o (max_degree_out_o),
    .total_entries_o  (total_entries_o)
  );

  `ECB_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, q_push, !q_full)
  `ECB_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, q_pop, !q_empty)
  `ECB_ASSERT_IMP(a_stall_clear, clk_i, rst_ni, clearing, in_stall_o)
  `ECB_ASSERT_NEXT(a_pop_holds_q, clk_i, rst_ni, q_pop, !q_pop)

endmodule

### dv/edge_list_to_csr_builder_tb.sv
// Self-checking testbench for the edge list to CSR builder.
`timescale 1ns / 1ps

module edge_list_to_csr_builder_tb;
  import ecb_pkg::*;

  localparam int NumVertices = DefMaxVertices;
  localparam int NumEdges    = DefMaxEdges;
  localparam int CycleLimit  = 2000000;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  value;
    logic [MaxDegW-1:0] peak_degree;
    logic [TotalW-1:0]  total;
  } csr_word_t;

  class csr_scoreboard;
    int unsigned vertex_count;
    int unsigned edge_a[NumEdges];
    int unsigned edge_b[NumEdges];
    int unsigned kept;
    int unsigned degree[NumVertices];
    int unsigned offset[NumVertices+1];
    int unsigned cursor[NumVertices];
    int unsigned neighbor[2*NumEdges];
    int unsigned peak_degree;
    bit          built;
    csr_word_t   expected_words[$];
    int          errors;

    function new();
      vertex_count = VcReset;
      kept = 0;
      peak_degree = 0;
      built = 0;
      errors = 0;
      foreach (degree[v]) begin
        degree[v] = 0;
        cursor[v] = 0;
      end
    endfunction

    function void build_csr();
      int unsigned a, b;
      offset[0] = 0;
      peak_degree = 0;
      for (int v = 0; v < NumVertices; v++) begin
        offset[v+1] = offset[v] + degree[v];
        if (degree[v] > peak_degree) peak_degree = degree[v];
      end
      for (int e = 0; e < kept; e++) begin
        a = edge_a[e];
        b = edge_b[e];
        neighbor[offset[a] + cursor[a]] = b;
        neighbor[offset[b] + cursor[b]] = a;
        cursor[a]++;
        cursor[b]++;
      end
      built = 1;
    endfunction

    function void predict_item(op_e op, logic [IdW-1:0] src, logic [IdW-1:0] dst,
                               logic [IdxW-1:0] idx);
      csr_word_t w;
      longint unsigned nv;
      nv = (vertex_count > NumVertices) ? NumVertices : vertex_count;
      w.status = ST_OK;
      w.value = '0;
      if (op == OP_ADD) begin
        if (built) w.status = ST_PHASE;
        else if (src >= nv || dst >= nv) w.status = ST_RANGE;
        else if (src == dst) w.status = ST_SELF;
        else if (kept >= NumEdges) w.status = ST_FULL;
        else begin
          edge_a[kept] = src;
          edge_b[kept] = dst;
          kept++;
          degree[src]++;
          degree[dst]++;
        end
      end else if (op == OP_FIN) begin
        if (built) w.status = ST_PHASE;
        else build_csr();
      end else if (!built) begin
        w.status = ST_PHASE;
      end else if (op == OP_RD_OFF) begin
        if (idx > nv) w.status = ST_INDEX;
        else w.value = ValueW'(offset[idx]);
      end else begin
        if (idx >= offset[NumVertices]) w.status = ST_INDEX;
        else w.value = ValueW'(neighbor[idx]);
      end
      w.peak_degree = MaxDegW'(peak_degree);
      w.total = built ? TotalW'(offset[NumVertices]) : '0;
      expected_words.push_back(w);
    endfunction

    function void check_word(csr_word_t got);
      csr_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("Unexpected result word: status %0d", got.status);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, actual %0d", exp_w.status, got.status);
        errors++;
      end
      if (got.value !== exp_w.value) begin
        $error("read_value: expected %0d, actual %0d", exp_w.value, got.value);
        errors++;
      end
      if (got.peak_degree !== exp_w.peak_degree) begin
        $error("max_degree_out: expected %0d, actual %0d", exp_w.peak_degree,
               got.peak_degree);
        errors++;
      end
      if (got.total !== exp_w.total) begin
        $error("total_entries: expected %0d, actual %0d", exp_w.total, got.total);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [VcW-1:0]     cfg_vertex_count_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [FuncW-1:0]   func_i;
  logic [IdW-1:0]     edge_source_i;
  logic [IdW-1:0]     edge_target_i;
  logic [IdxW-1:0]    read_index_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [StatusW-1:0] status_o;
  logic [ValueW-1:0]  read_value_o;
  logic [MaxDegW-1:0] max_degree_out_o;
  logic [TotalW-1:0]  total_entries_o;

  csr_scoreboard sb = new();
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  int unsigned cycles;

  edge_list_to_csr_builder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .edge_source_i      (edge_source_i),
    .edge_target_i      (edge_target_i),
    .read_index_i       (read_index_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .read_value_o       (read_value_o),
    .max_degree_out_o   (max_degree_out_o),
    .total_entries_o    (total_entries_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("edge_list_to_csr_builder_tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    csr_word_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_o;
      got.value = read_value_o;
      got.peak_degree = max_degree_out_o;
      got.total = total_entries_o;
      sb.check_word(got);
    end
  end

  task automatic send_word(op_e op, logic [IdW-1:0] src, logic [IdW-1:0] dst,
                           logic [IdxW-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i = op;
    edge_source_i = src;
    edge_target_i = dst;
    read_index_i = idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.predict_item(op, src, dst, idx);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_vertex_count(int unsigned vc);
    drain();
    cfg_valid_i = 1'b1;
    cfg_vertex_count_i = VcW'(vc);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.vertex_count = vc;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic int unsigned pick_vertex_count();
    case ($urandom_range(5))
      0: return 1;
      1: return 2;
      2: return 16;
      3: return 1024;
      4: return 2047;
      default: return $urandom_range(1, 2047);
    endcase
  endfunction

  task automatic send_random_edge(int unsigned nv);
    int unsigned a, b;
    if ($urandom_range(99) < 80) begin
      a = $urandom_range(nv - 1);
      b = $urandom_range(nv - 1);
      if (a == b && nv > 1) b = (a + 1) % nv;
      send_word(OP_ADD, a, b, IdxW'($urandom));
    end else begin
      case ($urandom_range(2))
        0: send_word(OP_ADD, $urandom, $urandom, IdxW'($urandom));
        1: begin
          a = $urandom_range(nv - 1);
          send_word(OP_ADD, a, a, IdxW'($urandom));
        end
        default: send_word(OP_ADD, nv, $urandom_range(nv - 1), IdxW'($urandom));
      endcase
    end
  endtask

  initial begin
    int idle_modes[4][2];
    int unsigned nv;
    idle_modes = '{'{0, 0}, '{85, 0}, '{0, 85}, '{21, 21}};
    rst_ni = 1'b0;
    cycles = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_valid_i = 1'b0;
    cfg_vertex_count_i = VcReset;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    func_i = OP_ADD;
    edge_source_i = '0;
    edge_target_i = '0;
    read_index_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_vertex_count(1024);
    send_word(OP_RD_OFF, 0, 0, 0);
    send_word(OP_RD_NB, 0, 0, 13'h1fff);
    send_word(OP_ADD, 0, 1023, 0);
    send_word(OP_ADD, 1023, 0, 13'h1fff);
    send_word(OP_ADD, 1024, 5, 0);
    send_word(OP_ADD, 5, 1024, 0);
    send_word(OP_ADD, 32'hffffffff, 0, 0);
    send_word(OP_ADD, 0, 32'hffffffff, 0);
    send_word(OP_ADD, 7, 7, 0);
    send_word(OP_ADD, 2000, 2000, 0);
    send_word(OP_ADD, 0, 1, 0);
    write_vertex_count(1);
    send_word(OP_ADD, 0, 0, 0);
    send_word(OP_ADD, 0, 1, 0);
    write_vertex_count(2047);
    send_word(OP_ADD, 1500, 3, 0);
    send_word(OP_ADD, 1, 1023, 0);

    // Edge loading under every idling pattern and a spread of vertex counts.
    for (int m = 0; m < 4; m++) begin
      for (int p = 0; p < 2; p++) begin
        write_vertex_count(pick_vertex_count());
        nv = (sb.vertex_count > NumVertices) ? NumVertices : sb.vertex_count;
        send_idle_pct = idle_modes[m][0];
        recv_stall_pct = idle_modes[m][1];
        repeat (35) send_random_edge(nv);
      end
    end

    // A long receiver hold-off backs up the queue and stalls the input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_vertex_count(1024);
    repeat (50) send_random_edge(NumVertices);
    hold_left = 400;
    repeat (90) send_random_edge(NumVertices);
    send_word(OP_ADD, 3, 4, 0);
    send_word(OP_FIN, 0, 0, 0);
    send_word(OP_FIN, 0, 0, 0);
    send_word(OP_ADD, 1, 2, 0);
    drain();

    // Reads of the built CSR arrays.
    for (int m = 0; m < 4; m++) begin
      for (int p = 0; p < 2; p++) begin
        write_vertex_count(pick_vertex_count());
        nv = (sb.vertex_count > NumVertices) ? NumVertices : sb.vertex_count;
        send_idle_pct = idle_modes[m][0];
        recv_stall_pct = idle_modes[m][1];
        send_word(OP_RD_OFF, 0, 0, IdxW'(nv));
        send_word(OP_RD_OFF, 0, 0, IdxW'(nv + 1));
        send_word(OP_RD_OFF, 0, 0, 13'h1fff);
        send_word(OP_RD_NB, 0, 0, 13'h1fff);
        repeat (60) begin
          case ($urandom_range(3))
            0: send_word(OP_RD_OFF, $urandom, $urandom, IdxW'($urandom_range(nv + 2)));
            1: send_word(OP_RD_OFF, $urandom, $urandom, IdxW'($urandom));
            default: send_word(OP_RD_NB, $urandom, $urandom, IdxW'($urandom));
          endcase
        end
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("edge_list_to_csr_builder_tb OK");
    end else begin
      $display("edge_list_to_csr_builder_tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ecb_pkg.sv
rtl/ecb_fifo.sv
rtl/ecb_front.sv
rtl/ecb_back.sv
rtl/edge_list_to_csr_builder.sv
dv/edge_list_to_csr_builder_tb.sv
